@@ src/lmsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix segment mapper package
// Shared types, register codes, reset values and the divider step function.
// ----------------------------------------------------------------------------
package lmsm_pkg;

    localparam int unsigned SEG_SLOTS  = 4;
    localparam int unsigned CUM_W      = 18;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DIV_BITS   = 16;
    localparam int unsigned DIV_STEPS  = 2;
    localparam int unsigned DIV_STAGES = DIV_BITS / DIV_STEPS;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_SERP   = 3'd2,
        REG_SEGS   = 3'd3,
        REG_LEN0   = 3'd4,
        REG_LEN1   = 3'd5,
        REG_LEN2   = 3'd6,
        REG_LEN3   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_BEYOND = 2'd2
    } status_t;

    localparam logic [15:0] WIDTH_RESET  = 16'd30;
    localparam logic [15:0] HEIGHT_RESET = 16'd40;
    localparam logic        SERP_RESET   = 1'b1;
    localparam logic [2:0]  SEGS_RESET   = 3'd3;
    localparam logic [SEG_SLOTS-1:0][15:0] LEN_RESET = {16'd0, 16'd400, 16'd400, 16'd400};

    // Configuration as seen by the datapath; cum[s] is the end of segment s
    typedef struct packed {
        logic [15:0]                       width;
        logic [15:0]                       height;
        logic                              serp;
        logic [2:0]                        limit;
        logic [31:0]                       total;
        logic [SEG_SLOTS-1:0][CUM_W-1:0]   cum;
    } cfg_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] column;
        logic [15:0] row;
        logic [31:0] linear_index;
    } req_t;

    typedef struct packed {
        logic        rng_err;
        logic [15:0] x;
        logic [15:0] y;
    } pos_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  segment_number;
        logic [15:0] led_in_segment;
        logic [31:0] global_led;
    } res_t;

    typedef struct packed {
        logic [15:0] quo;
        logic [31:0] rem;
    } div_acc_t;

    // Restoring division: DIV_STEPS quotient bits, starting at bit top
    function automatic div_acc_t div_stage(input logic [31:0] rem, input logic [15:0] quo,
                                           input logic [15:0] dvs, input int unsigned top);
        div_acc_t    acc;
        logic [31:0] d;
        acc.rem = rem;
        acc.quo = quo;
        for (int j = 0; j < int'(DIV_STEPS); j++)
        begin
            d = 32'(dvs) << (int'(top) - j);
            if (acc.rem >= d)
            begin
                acc.rem = acc.rem - d;
                acc.quo[int'(top) - j] = 1'b1;
            end
        end
        return acc;
    endfunction

endpackage

@@ src/lmsm_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix segment mapper register file
// APB register bank plus registered derived values: matrix size product,
// segment count limit and cumulative segment ends.
// ----------------------------------------------------------------------------
module lmsm_regs #(
    parameter int unsigned MAX_SEGMENTS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lmsm_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output lmsm_pkg::cfg_t                   cfg
);

    logic                 wr_en;
    lmsm_pkg::reg_idx_t   wr_idx;
    logic [15:0]          width_reg;
    logic [15:0]          height_reg;
    logic                 serp_reg;
    logic [2:0]           segs_reg;
    logic [15:0]          len_all [lmsm_pkg::SEG_SLOTS];
    logic [lmsm_pkg::SEG_SLOTS-1:0][lmsm_pkg::CUM_W-1:0] cum_next;
    logic [lmsm_pkg::SEG_SLOTS-1:0][lmsm_pkg::CUM_W-1:0] cum_reg;
    logic [2:0]           limit_next;
    logic [2:0]           limit_reg;
    logic [31:0]          total_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = lmsm_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lmsm_pkg::WIDTH_RESET;
            height_reg <= lmsm_pkg::HEIGHT_RESET;
            serp_reg   <= lmsm_pkg::SERP_RESET;
            segs_reg   <= lmsm_pkg::SEGS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                lmsm_pkg::REG_WIDTH:  width_reg  <= pwdata[15:0];
                lmsm_pkg::REG_HEIGHT: height_reg <= pwdata[15:0];
                lmsm_pkg::REG_SERP:   serp_reg   <= pwdata[0];
                lmsm_pkg::REG_SEGS:   segs_reg   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Only the segments that can be in use get storage
    for (genvar s = 0; s < int'(lmsm_pkg::SEG_SLOTS); s++)
    begin : g_len
        if (s < int'(MAX_SEGMENTS))
        begin : g_stored
            logic [15:0] len_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    len_reg <= lmsm_pkg::LEN_RESET[s];
                else if (wr_en && (wr_idx == lmsm_pkg::reg_idx_t'(3'(lmsm_pkg::REG_LEN0) + 3'(s))))
                    len_reg <= pwdata[15:0];
            end
            assign len_all[s] = len_reg;
        end
        else
        begin : g_absent
            assign len_all[s] = '0;
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            lmsm_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            lmsm_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            lmsm_pkg::REG_SERP:   prdata = 32'(serp_reg);
            lmsm_pkg::REG_SEGS:   prdata = 32'(segs_reg);
            lmsm_pkg::REG_LEN0:   prdata = 32'(len_all[0]);
            lmsm_pkg::REG_LEN1:   prdata = 32'(len_all[1]);
            lmsm_pkg::REG_LEN2:   prdata = 32'(len_all[2]);
            lmsm_pkg::REG_LEN3:   prdata = 32'(len_all[3]);
        endcase
    end

    always_comb
    begin
        cum_next[0] = lmsm_pkg::CUM_W'(len_all[0]);
        for (int s = 1; s < int'(lmsm_pkg::SEG_SLOTS); s++)
            cum_next[s] = cum_next[s-1] + lmsm_pkg::CUM_W'(len_all[s]);
        limit_next = (segs_reg > 3'(MAX_SEGMENTS)) ? 3'(MAX_SEGMENTS) : segs_reg;
    end

    // Derived values are registered, so they follow the registers in the next cycle
    always_ff @(posedge clk)
    begin
        total_reg <= 32'(width_reg) * 32'(height_reg);
        cum_reg   <= cum_next;
        limit_reg <= limit_next;
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.serp   = serp_reg;
    assign cfg.limit  = limit_reg;
    assign cfg.total  = total_reg;
    assign cfg.cum    = cum_reg;

endmodule

@@ src/lmsm_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix segment mapper front end
// Input register, range check and pipelined restoring divider that splits a
// linear index into column and row, two quotient bits per stage.
// ----------------------------------------------------------------------------
module lmsm_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lmsm_pkg::req_t       in_req,
    input  lmsm_pkg::cfg_t       cfg,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lmsm_pkg::pos_t       out_pos
);

    localparam int unsigned NS = lmsm_pkg::DIV_STAGES;

    logic                 in_valid_reg;
    lmsm_pkg::req_t       in_req_reg;
    logic                 rng_first;
    logic [NS+1:0]        rdy;
    logic [NS:1]          valid_reg;
    logic                 op_reg  [1:NS];
    logic                 rng_reg [1:NS];
    logic [15:0]          col_reg [1:NS];
    logic [15:0]          row_reg [1:NS];
    lmsm_pkg::div_acc_t   acc_reg [1:NS];
    lmsm_pkg::div_acc_t   acc_next[1:NS];

    // A stage takes a new item when empty or when its content moves on
    always_comb
    begin
        rdy[NS+1] = out_ready;
        for (int k = int'(NS); k >= 1; k--)
            rdy[k] = !valid_reg[k] || rdy[k+1];
        rdy[0] = !in_valid_reg || rdy[1];
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        if (in_req_reg.opcode)
            rng_first = (in_req_reg.linear_index >= cfg.total);
        else
            rng_first = (in_req_reg.column >= cfg.width) || (in_req_reg.row >= cfg.height);
    end

    for (genvar k = 1; k <= int'(NS); k++)
    begin : g_stage
        if (k == 1)
        begin : g_first
            assign acc_next[k] = lmsm_pkg::div_stage(in_req_reg.linear_index, '0, cfg.width,
                                                     lmsm_pkg::DIV_BITS - 1);
        end
        else
        begin : g_next
            assign acc_next[k] = lmsm_pkg::div_stage(acc_reg[k-1].rem, acc_reg[k-1].quo,
                cfg.width, lmsm_pkg::DIV_BITS - 1 - (k - 1) * lmsm_pkg::DIV_STEPS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            if (rdy[0])
                in_valid_reg <= in_valid;
            if (rdy[1])
                valid_reg[1] <= in_valid_reg;
            for (int k = 2; k <= int'(NS); k++)
                if (rdy[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
            in_req_reg <= in_req;
        if (rdy[1] && in_valid_reg)
        begin
            op_reg[1]  <= in_req_reg.opcode;
            rng_reg[1] <= rng_first;
            col_reg[1] <= in_req_reg.column;
            row_reg[1] <= in_req_reg.row;
            acc_reg[1] <= acc_next[1];
        end
        for (int k = 2; k <= int'(NS); k++)
        begin
            if (rdy[k] && valid_reg[k-1])
            begin
                op_reg[k]  <= op_reg[k-1];
                rng_reg[k] <= rng_reg[k-1];
                col_reg[k] <= col_reg[k-1];
                row_reg[k] <= row_reg[k-1];
                acc_reg[k] <= acc_next[k];
            end
        end
    end

    // Remainder is the column, quotient the row
    assign out_valid       = valid_reg[NS];
    assign out_pos.rng_err = rng_reg[NS];
    assign out_pos.x       = op_reg[NS] ? acc_reg[NS].rem[15:0] : col_reg[NS];
    assign out_pos.y       = op_reg[NS] ? acc_reg[NS].quo : row_reg[NS];

endmodule

@@ src/lmsm_locate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix segment mapper back end
// Serpentine fold, column-major index, segment search and offset, with the
// result held in the output register.
// ----------------------------------------------------------------------------
module lmsm_locate (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lmsm_pkg::pos_t       in_pos,
    input  lmsm_pkg::cfg_t       cfg,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lmsm_pkg::res_t       out_res
);

    logic                 l1_ready, l2_ready, l3_ready, out_stage_ready;

    logic                 l1_valid_reg;
    logic                 l1_rng_reg;
    logic [15:0]          l1_x_reg;
    logic [15:0]          l1_y_reg;
    logic [15:0]          y_next;

    logic                 l2_valid_reg;
    logic                 l2_rng_reg;
    logic [31:0]          l2_glob_reg;

    logic                 l3_valid_reg;
    lmsm_pkg::status_t    l3_status_reg;
    logic [1:0]           l3_seg_reg;
    logic [lmsm_pkg::CUM_W-1:0] l3_base_reg;
    logic [31:0]          l3_glob_reg;
    lmsm_pkg::status_t    status_next;
    logic [1:0]           seg_next;
    logic [lmsm_pkg::CUM_W-1:0] base_next;

    logic                 out_valid_reg;
    lmsm_pkg::res_t       out_res_reg;
    lmsm_pkg::res_t       res_next;

    assign out_stage_ready = !out_valid_reg || out_ready;
    assign l3_ready        = !l3_valid_reg || out_stage_ready;
    assign l2_ready        = !l2_valid_reg || l3_ready;
    assign l1_ready        = !l1_valid_reg || l2_ready;
    assign in_ready        = l1_ready;

    // Odd columns run bottom to top in serpentine mode
    assign y_next = (cfg.serp && in_pos.x[0]) ? (cfg.height - 16'd1 - in_pos.y) : in_pos.y;

    // First segment in use whose end lies above the index
    always_comb
    begin
        logic                       found;
        logic [lmsm_pkg::CUM_W-1:0] prev;
        found    = 1'b0;
        prev     = '0;
        seg_next = '0;
        base_next = '0;
        for (int s = 0; s < int'(lmsm_pkg::SEG_SLOTS); s++)
        begin
            if (!found && (3'(s) < cfg.limit) && (l2_glob_reg < 32'(cfg.cum[s])))
            begin
                found     = 1'b1;
                seg_next  = 2'(s);
                base_next = prev;
            end
            prev = cfg.cum[s];
        end
        priority if (l2_rng_reg)
            status_next = lmsm_pkg::ST_RANGE;
        else if (found)
            status_next = lmsm_pkg::ST_OK;
        else
            status_next = lmsm_pkg::ST_BEYOND;
    end

    always_comb
    begin
        res_next.status = l3_status_reg;
        if (l3_status_reg == lmsm_pkg::ST_OK)
        begin
            res_next.segment_number = l3_seg_reg;
            res_next.led_in_segment = 16'(l3_glob_reg - 32'(l3_base_reg));
            res_next.global_led     = l3_glob_reg;
        end
        else
        begin
            res_next.segment_number = '0;
            res_next.led_in_segment = '0;
            res_next.global_led     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg  <= 1'b0;
            l2_valid_reg  <= 1'b0;
            l3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (l1_ready)
                l1_valid_reg <= in_valid;
            if (l2_ready)
                l2_valid_reg <= l1_valid_reg;
            if (l3_ready)
                l3_valid_reg <= l2_valid_reg;
            if (out_stage_ready)
                out_valid_reg <= l3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (l1_ready && in_valid)
        begin
            l1_rng_reg <= in_pos.rng_err;
            l1_x_reg   <= in_pos.x;
            l1_y_reg   <= y_next;
        end
        if (l2_ready && l1_valid_reg)
        begin
            l2_rng_reg  <= l1_rng_reg;
            l2_glob_reg <= 32'(l1_x_reg) * 32'(cfg.height) + 32'(l1_y_reg);
        end
        if (l3_ready && l2_valid_reg)
        begin
            l3_status_reg <= status_next;
            l3_seg_reg    <= seg_next;
            l3_base_reg   <= base_next;
            l3_glob_reg   <= l2_glob_reg;
        end
        if (out_stage_ready && l3_valid_reg)
            out_res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

@@ src/led_matrix_segment_mapper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix segment mapper
// Pipeline: input register, 8 divider stages of 2 quotient bits each, 3 locate
// stages and the output register. Throughput: one item per cycle while
// m_axis_tready is high; the divider pipeline sets the depth.
// Reset clears all valid bits and loads the register defaults
// (30 x 40 matrix, serpentine, 3 segments of 400 LEDs).
// ----------------------------------------------------------------------------
module led_matrix_segment_mapper #(
    parameter int unsigned MAX_SEGMENTS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [63:0]                      s_axis_tdata,  // column, row, linear_index
    input  logic                             s_axis_tuser,  // opcode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // segment_number, led_in_segment, global_led, zero fill
    output logic [55:0]                      m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,  // status
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lmsm_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    lmsm_pkg::cfg_t   cfg;
    lmsm_pkg::req_t   req;
    lmsm_pkg::pos_t   pos;
    lmsm_pkg::res_t   res;
    logic             pos_valid;
    logic             pos_ready;

    assign req.opcode       = s_axis_tuser;
    assign req.column       = s_axis_tdata[15:0];
    assign req.row          = s_axis_tdata[31:16];
    assign req.linear_index = s_axis_tdata[63:32];

    lmsm_regs #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lmsm_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (req),
        .cfg       (cfg),
        .out_valid (pos_valid),
        .out_ready (pos_ready),
        .out_pos   (pos)
    );

    lmsm_locate u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pos_valid),
        .in_ready  (pos_ready),
        .in_pos    (pos),
        .cfg       (cfg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tuser        = res.status;
    assign m_axis_tdata[1:0]   = res.segment_number;
    assign m_axis_tdata[17:2]  = res.led_in_segment;
    assign m_axis_tdata[49:18] = res.global_led;
    assign m_axis_tdata[55:50] = '0;

endmodule

@@ sim/tb_led_matrix_segment_mapper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix segment mapper testbench
// Streams column/row and linear-index positions through the mapper under a
// series of matrix and strip layouts and checks each physical location it
// returns against a local model of the serpentine, column-major mapping.
// Configuration goes through the APB port while the stream is idle.
// ----------------------------------------------------------------------------
module tb_led_matrix_segment_mapper;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 16;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    // Shadow of the mapper registers
    typedef struct packed {
        logic [15:0]       width;
        logic [15:0]       height;
        logic              serp;
        logic [2:0]        segs;
        logic [3:0][15:0]  seg_len;
    } layout_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // column, row, linear_index
    logic        s_axis_tuser = 1'b0; // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // segment_number, led_in_segment, global_led, zero fill
    logic [1:0]  m_axis_tuser;        // status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [lmsm_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    layout_t            layout;
    lmsm_pkg::req_t     pixel_q[$];
    lmsm_pkg::res_t     location_q[$];
    lmsm_pkg::req_t     pixel_on_bus;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_mode_left = 0;
    int unsigned rx_tick = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    led_matrix_segment_mapper #(
        .MAX_SEGMENTS(4)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Expected physical location of one pixel under the current layout
    function automatic lmsm_pkg::res_t map_position(input lmsm_pkg::req_t px);
        lmsm_pkg::res_t loc;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] my;
        logic [31:0] glob;
        logic [31:0] base;
        logic [31:0] total;
        int unsigned lim;
        loc = '0;
        loc.status = lmsm_pkg::ST_RANGE;
        total = 32'(layout.width) * 32'(layout.height);
        if (px.opcode)
        begin
            if (px.linear_index >= total)
                return loc;
            x = px.linear_index % 32'(layout.width);
            y = px.linear_index / 32'(layout.width);
        end
        else
        begin
            x = 32'(px.column);
            y = 32'(px.row);
        end
        if (x >= 32'(layout.width) || y >= 32'(layout.height))
            return loc;
        my = (layout.serp && x[0]) ? 32'(layout.height) - 32'd1 - y : y;
        glob = x * 32'(layout.height) + my;
        lim = (layout.segs > 3'd4) ? 4 : int'(layout.segs);
        base = '0;
        for (int s = 0; s < lim; s++)
        begin
            if (glob < base + 32'(layout.seg_len[s]))
            begin
                loc.status = lmsm_pkg::ST_OK;
                loc.segment_number = 2'(s);
                loc.led_in_segment = 16'(glob - base);
                loc.global_led = glob;
                return loc;
            end
            base = base + 32'(layout.seg_len[s]);
        end
        loc.status = lmsm_pkg::ST_BEYOND;
        return loc;
    endfunction

    // Mostly positions inside the matrix, some on its border, the rest anywhere
    function automatic lmsm_pkg::req_t random_pixel();
        lmsm_pkg::req_t px;
        logic [31:0] total;
        int unsigned pick;
        total = 32'(layout.width) * 32'(layout.height);
        pick = $urandom_range(0, 9);
        px.opcode = 1'($urandom_range(0, 1));
        px.column = 16'($urandom);
        px.row = 16'($urandom);
        px.linear_index = $urandom;
        if (pick < 7 && total != 0)
        begin
            px.column = 16'($urandom_range(0, int'(layout.width) - 1));
            px.row = 16'($urandom_range(0, int'(layout.height) - 1));
            px.linear_index = $urandom_range(0, total - 32'd1);
        end
        else if (pick < 9)
        begin
            px.column = layout.width - 16'($urandom_range(0, 1));
            px.row = layout.height - 16'($urandom_range(0, 1));
            px.linear_index = total - 32'($urandom_range(0, 1));
        end
        return px;
    endfunction

    task automatic add_random(input int unsigned count);
        repeat (count) pixel_q.push_back(random_pixel());
    endtask

    task automatic add_xy(input logic [15:0] col, input logic [15:0] row);
        pixel_q.push_back('{opcode: 1'b0, column: col, row: row, linear_index: $urandom});
    endtask

    task automatic add_index(input logic [31:0] idx);
        pixel_q.push_back('{opcode: 1'b1, column: 16'($urandom), row: 16'($urandom),
                            linear_index: idx});
    endtask

    // Setup and access cycle; upper bits carry junk that the register drops
    task automatic write_reg(input lmsm_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] mask;
        case (idx)
            lmsm_pkg::REG_SERP: mask = 32'h1;
            lmsm_pkg::REG_SEGS: mask = 32'h7;
            default:            mask = 32'hFFFF;
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~mask) | (value & mask);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lmsm_pkg::REG_WIDTH:  layout.width = 16'(value & mask);
            lmsm_pkg::REG_HEIGHT: layout.height = 16'(value & mask);
            lmsm_pkg::REG_SERP:   layout.serp = value[0];
            lmsm_pkg::REG_SEGS:   layout.segs = value[2:0];
            lmsm_pkg::REG_LEN0:   layout.seg_len[0] = 16'(value & mask);
            lmsm_pkg::REG_LEN1:   layout.seg_len[1] = 16'(value & mask);
            lmsm_pkg::REG_LEN2:   layout.seg_len[2] = 16'(value & mask);
            lmsm_pkg::REG_LEN3:   layout.seg_len[3] = 16'(value & mask);
        endcase
    endtask

    task automatic set_layout(input logic [15:0] w, input logic [15:0] h, input logic serp,
                              input logic [2:0] segs, input logic [15:0] l0,
                              input logic [15:0] l1, input logic [15:0] l2,
                              input logic [15:0] l3);
        write_reg(lmsm_pkg::REG_WIDTH, 32'(w));
        write_reg(lmsm_pkg::REG_HEIGHT, 32'(h));
        write_reg(lmsm_pkg::REG_SERP, 32'(serp));
        write_reg(lmsm_pkg::REG_SEGS, 32'(segs));
        write_reg(lmsm_pkg::REG_LEN0, 32'(l0));
        write_reg(lmsm_pkg::REG_LEN1, 32'(l1));
        write_reg(lmsm_pkg::REG_LEN2, 32'(l2));
        write_reg(lmsm_pkg::REG_LEN3, 32'(l3));
    endtask

    // Hold until every pixel has gone through and its result came back
    task automatic wait_idle();
        while (pixel_q.size() != 0 || s_axis_tvalid || location_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [15:0] random_len(input int unsigned cells);
        if ($urandom_range(0, 5) == 0)
            return 16'd0;
        return 16'($urandom_range(1, cells / 3 + 2));
    endfunction

    // Stream driver: bursts of transfers separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                location_q.push_back(map_position(pixel_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_q.size() != 0)
                begin
                    pixel_on_bus = pixel_q.pop_front();
                    s_axis_tdata  <= {pixel_on_bus.linear_index, pixel_on_bus.row,
                                      pixel_on_bus.column};
                    s_axis_tuser  <= pixel_on_bus.opcode;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge clk)
    begin
        lmsm_pkg::res_t got;
        lmsm_pkg::res_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = lmsm_pkg::status_t'(m_axis_tuser);
                got.segment_number = m_axis_tdata[1:0];
                got.led_in_segment = m_axis_tdata[17:2];
                got.global_led = m_axis_tdata[49:18];
                if (location_q.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d seg=%0d led=%0d global=%0d",
                             $time, got.status, got.segment_number, got.led_in_segment,
                             got.global_led);
                    error_count++;
                end
                else
                begin
                    want = location_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected status=%0d seg=%0d led=%0d global=%0d",
                                 $time, want.status, want.segment_number, want.led_in_segment,
                                 want.global_led);
                        $display("%0t:          actual   status=%0d seg=%0d led=%0d global=%0d",
                                 $time, got.status, got.segment_number, got.led_in_segment,
                                 got.global_led);
                        error_count++;
                    end
                end
            end
            if (rx_mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(8, 64);
            end
            else
            begin
                rx_mode_left = rx_mode_left - 1;
            end
            rx_tick = rx_tick + 1;
            case (rx_mode)
                RX_OPEN:  m_axis_tready <= 1'b1;
                RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:  m_axis_tready <= (rx_tick % 5 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] w;
        logic [15:0] h;
        layout.width = lmsm_pkg::WIDTH_RESET;
        layout.height = lmsm_pkg::HEIGHT_RESET;
        layout.serp = lmsm_pkg::SERP_RESET;
        layout.segs = lmsm_pkg::SEGS_RESET;
        layout.seg_len = lmsm_pkg::LEN_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset layout: 30 x 40, serpentine, three strips of 400
        add_xy(16'd0, 16'd0);
        add_xy(16'd29, 16'd39);
        add_xy(16'd1, 16'd0);       // odd column runs bottom to top
        add_xy(16'd1, 16'd39);
        add_xy(16'd9, 16'd39);
        add_xy(16'd10, 16'd0);      // first LED of the second strip
        add_xy(16'd29, 16'd0);      // last LED of the third strip
        add_xy(16'd30, 16'd0);      // column past the edge
        add_xy(16'd0, 16'd40);      // row past the edge
        add_xy(16'hFFFF, 16'hFFFF);
        add_xy(16'd20, 16'd17);
        add_index(32'd0);
        add_index(32'd31);
        add_index(32'd1199);
        add_index(32'd1200);        // one past the last pixel
        add_index(32'hFFFF_FFFF);
        add_index(32'd59);
        add_index(32'd600);
        add_random(300);
        wait_idle();

        // Widest layout; most positions land beyond the strips
        set_layout(16'hFFFF, 16'hFFFF, 1'b1, 3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_xy(16'd0, 16'hFFFE);
        add_xy(16'd3, 16'd0);
        add_xy(16'hFFFE, 16'hFFFE);
        add_index(32'hFFFE_0000);
        add_random(150);
        wait_idle();

        // Empty matrix and no strips: every position is out of range
        set_layout(16'd0, 16'd0, 1'b0, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        add_random(60);
        wait_idle();

        // Single pixel held by the second strip; strip count above the maximum
        set_layout(16'd1, 16'd1, 1'b0, 3'd7, 16'd0, 16'd1, 16'd0, 16'd0);
        add_random(80);
        wait_idle();

        repeat (8)
        begin
            w = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 48));
            h = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 48));
            set_layout(w, h, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                       random_len(48 * 48), random_len(48 * 48), random_len(48 * 48),
                       random_len(48 * 48));
            add_random(130);
            wait_idle();
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
